@@ rtl/crcfa_pkg.sv @@
// Shared types, constants and the CRC-32 byte update for the CRC framer/checker.
`default_nettype none
package crcfa_pkg;

  // Fixed field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CRC_W     = 32;
  localparam int unsigned CFG_LEN_W = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 13;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_FRAME_PAYLOAD = 4096;
  localparam int unsigned QUEUE_DEPTH       = 2;

  // CRC constants (reflected CRC-32)
  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LEN = 2'd1;
  localparam logic [CFG_LEN_W-1:0] PAYLOAD_LEN_RST = 13'd9;

  // Beat index of the last appended CRC byte in a generated frame end
  localparam logic [2:0] LAST_CRC_BEAT = 3'd4;

  // Work handed from the front to the back
  typedef enum logic [2:0] {
    JOB_FWD     = 3'b001,  // forward one payload byte
    JOB_FWD_CRC = 3'b010,  // forward one payload byte, then four CRC bytes
    JOB_STATUS  = 3'b100   // one check status result
  } job_kind_e;

  typedef struct packed {
    job_kind_e         kind;
    logic [BYTE_W-1:0] data;
    logic [CRC_W-1:0]  crc;    // final (inverted) CRC for appended bytes
    logic              pass;
  } job_t;

  // One byte through the reflected CRC, LSB first
  function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/crcfa_if.sv @@
// Valid/ready stream interfaces for the input bytes and the results.
`default_nettype none
interface crcfa_in_if;
  import crcfa_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_payload;

  modport source (output valid, output data_byte, output end_of_payload, input ready);
  modport sink   (input valid, input data_byte, input end_of_payload, output ready);
endinterface

interface crcfa_out_if;
  import crcfa_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              is_check_byte;
  logic              frame_end;
  logic              check_done;
  logic              check_passed;

  modport source (output valid, output out_byte, output is_check_byte, output frame_end,
                  output check_done, output check_passed, input ready);
  modport sink   (input valid, input out_byte, input is_check_byte, input frame_end,
                  input check_done, input check_passed, output ready);
endinterface
`default_nettype wire

@@ rtl/crc32_frame_append_check.sv @@
// Top level of the byte-stream CRC-32 framer and checker.
//
// Channels: in_ch carries one frame byte per beat (data_byte, end_of_payload);
// out_ch carries result beats (out_byte, is_check_byte, frame_end, check_done,
// check_passed). Both are valid/ready; a beat moves when both are high.
// cfg_we_i/cfg_index_i/cfg_wdata_i write mode (index 0) or payload_length
// (index 1); either write restarts the current frame.
// An accepted byte's job is registered in the job queue; its results leave the head.
// Throughput: one input byte per cycle while the output takes one beat per
// cycle; a generate-mode end-of-payload byte yields five result beats, set by
// the back end emitting one beat per cycle. The front runs the CRC byte update
// combinationally and keeps accepting while the job queue has room.
// The first three received CRC bytes in check mode produce no result.
// Reset: check mode, payload_length 9, CRC preset to all ones, queue empty.
// Receiver stall: results wait in the job queue; input ready drops only when
// the queue is full.
`default_nettype none
module crc32_frame_append_check
  import crcfa_pkg::*;
#(
  parameter int unsigned MaxPayload = MAX_FRAME_PAYLOAD,
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  crcfa_in_if.sink                  in_ch,
  crcfa_out_if.source               out_ch,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata_i
);

  logic q_full, q_push, q_valid, q_pop;
  job_t q_job_in, q_job_out;

  // Accept and classify bytes
  crcfa_front #(
    .MaxPayload(MaxPayload)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_ch.valid),
    .in_ready_o       (in_ch.ready),
    .data_byte_i      (in_ch.data_byte),
    .end_of_payload_i (in_ch.end_of_payload),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_job_o          (q_job_in)
  );

  // Decouple front and back
  crcfa_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (q_job_out)
  );

  // Expand jobs into result beats
  crcfa_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_job_i         (q_job_out),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_ch.valid),
    .out_ready_i     (out_ch.ready),
    .out_byte_o      (out_ch.out_byte),
    .is_check_byte_o (out_ch.is_check_byte),
    .frame_end_o     (out_ch.frame_end),
    .check_done_o    (out_ch.check_done),
    .check_passed_o  (out_ch.check_passed)
  );

endmodule
`default_nettype wire

@@ rtl/crcfa_front.sv @@
// Front end: accepts bytes, runs the CRC and frame counters, emits jobs.
`default_nettype none
module crcfa_front
  import crcfa_pkg::*;
#(
  parameter int unsigned MaxPayload = MAX_FRAME_PAYLOAD
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input beat
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [BYTE_W-1:0]    data_byte_i,
  input  wire logic                 end_of_payload_i,
  // configuration writes
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata_i,
  // job queue
  input  wire logic                 q_full_i,
  output logic                      q_push_o,
  output job_t                      q_job_o
);

  localparam int unsigned PosW = $clog2(MaxPayload + 5);

  logic                 mode_q, mode_d;
  logic [CFG_LEN_W-1:0] len_q, len_d;
  logic [CRC_W-1:0]     crc_q, crc_d;
  logic [PosW-1:0]      pos_q, pos_d;
  logic [CRC_W-1:0]     rcv_q, rcv_d;

  logic                 accept;
  logic [PosW-1:0]      len_eff;
  logic [PosW-1:0]      pos_inc;
  logic [CRC_W-1:0]     crc_upd;
  logic [CRC_W-1:0]     rcv_shift;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Clamp the configured length to the supported maximum
  assign len_eff = (32'(len_q) > 32'(MaxPayload)) ? PosW'(MaxPayload) : PosW'(len_q);

  assign crc_upd   = crc32_byte(crc_q, data_byte_i);
  assign pos_inc   = pos_q + PosW'(1);
  assign rcv_shift = {rcv_q[CRC_W-BYTE_W-1:0], data_byte_i};

  // Classify the beat and advance the frame state
  always_comb begin
    mode_d        = mode_q;
    len_d         = len_q;
    crc_d         = crc_q;
    pos_d         = pos_q;
    rcv_d         = rcv_q;
    q_push_o      = 1'b0;
    q_job_o.kind  = JOB_FWD;
    q_job_o.data  = data_byte_i;
    q_job_o.crc   = ~crc_upd;
    q_job_o.pass  = 1'b0;

    if (cfg_we_i) begin
      if (cfg_index_i == REG_MODE) begin
        mode_d = cfg_wdata_i[0];
        crc_d  = CRC_INIT;
        pos_d  = '0;
        rcv_d  = '0;
      end else if (cfg_index_i == REG_PAYLOAD_LEN) begin
        len_d  = cfg_wdata_i[CFG_LEN_W-1:0];
        crc_d  = CRC_INIT;
        pos_d  = '0;
        rcv_d  = '0;
      end
    end else if (accept) begin
      if (mode_q) begin
        q_push_o = 1'b1;
        if (end_of_payload_i) begin
          q_job_o.kind = JOB_FWD_CRC;
          crc_d        = CRC_INIT;
        end else begin
          crc_d        = crc_upd;
        end
      end else if (pos_q < len_eff) begin
        q_push_o = 1'b1;
        crc_d    = crc_upd;
        pos_d    = pos_inc;
      end else if (32'(pos_inc) >= 32'(len_eff) + 32'd4) begin
        // fourth received CRC byte: report and restart
        q_push_o     = 1'b1;
        q_job_o.kind = JOB_STATUS;
        q_job_o.data = '0;
        q_job_o.pass = (rcv_shift == ~crc_q);
        crc_d        = CRC_INIT;
        pos_d        = '0;
        rcv_d        = '0;
      end else begin
        // gather a received CRC byte, no result
        rcv_d = rcv_shift;
        pos_d = pos_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      len_q  <= PAYLOAD_LEN_RST;
      crc_q  <= CRC_INIT;
      pos_q  <= '0;
      rcv_q  <= '0;
    end else begin
      mode_q <= mode_d;
      len_q  <= len_d;
      crc_q  <= crc_d;
      pos_q  <= pos_d;
      rcv_q  <= rcv_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/crcfa_queue.sv @@
// Short job queue between the front and the back.
`default_nettype none
module crcfa_queue
  import crcfa_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output job_t      job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold job payloads
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/crcfa_back.sv @@
// Back end: expands the head job into result beats.
`default_nettype none
module crcfa_back
  import crcfa_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // job queue head
  input  wire logic          q_valid_i,
  input  wire job_t          q_job_i,
  output logic               q_pop_o,
  // result beat
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [BYTE_W-1:0]  out_byte_o,
  output logic               is_check_byte_o,
  output logic               frame_end_o,
  output logic               check_done_o,
  output logic               check_passed_o
);

  logic [2:0] beat_q, beat_d;
  logic       last_beat;
  logic       take;

  assign out_valid_o = q_valid_i;
  assign take        = out_valid_o && out_ready_i;

  // Decode the current beat of the head job
  always_comb begin
    out_byte_o      = q_job_i.data;
    is_check_byte_o = 1'b0;
    frame_end_o     = 1'b0;
    check_done_o    = 1'b0;
    check_passed_o  = 1'b0;
    last_beat       = 1'b1;
    unique case (q_job_i.kind)
      JOB_FWD: begin
        last_beat = 1'b1;
      end
      JOB_FWD_CRC: begin
        last_beat = (beat_q == LAST_CRC_BEAT);
        if (beat_q != '0) begin
          is_check_byte_o = 1'b1;
          frame_end_o     = last_beat;
          unique case (beat_q)
            3'd1:    out_byte_o = q_job_i.crc[31:24];
            3'd2:    out_byte_o = q_job_i.crc[23:16];
            3'd3:    out_byte_o = q_job_i.crc[15:8];
            default: out_byte_o = q_job_i.crc[7:0];
          endcase
        end
      end
      JOB_STATUS: begin
        out_byte_o     = '0;
        frame_end_o    = 1'b1;
        check_done_o   = 1'b1;
        check_passed_o = q_job_i.pass;
      end
      default: begin
        last_beat = 1'b1;
      end
    endcase
  end

  // Advance within the job, drop it after its last beat
  always_comb begin
    beat_d  = beat_q;
    q_pop_o = 1'b0;
    if (take) begin
      if (last_beat) begin
        beat_d  = '0;
        q_pop_o = 1'b1;
      end else begin
        beat_d  = beat_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else begin
      beat_q <= beat_d;
    end
  end

endmodule
`default_nettype wire
